### design/urtx_pkg.sv
// ----------------------------------------------------------------------------
// urtx_pkg: shared types and constants for the serial receive ring block
// Event codes, field widths, default sizes and the control and status
// structs passed between the ring, the statistics counters and the top level.
// ----------------------------------------------------------------------------
package urtx_pkg;

  // default sizes
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_MAX_DEF   = 32;

  // fixed field widths
  localparam int KIND_W  = 3;
  localparam int DATA_W  = 8;
  localparam int LEN_W   = 8;
  localparam int AVAIL_W = 6;
  localparam int CNT_W   = 32;

  // event codes
  typedef enum logic [KIND_W-1:0] {
    KIND_RX_BYTE = 3'd0,
    KIND_READ    = 3'd1,
    KIND_TX_REQ  = 3'd2,
    KIND_TX_DONE = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_REINIT  = 3'd5
  } kind_t;

  // ring control from the event decoder
  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } ring_cmd_t;

  // ring status back to the event decoder
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [AVAIL_W-1:0] available;
  } ring_stat_t;

  // counter bumps from the event decoder
  typedef struct packed {
    logic drop;
    logic store;
    logic fault;
    logic sent;
    logic clr;
  } stat_inc_t;

endpackage

### design/urtx_ring.sv
// ----------------------------------------------------------------------------
// urtx_ring: receive byte ring with one slot kept empty
// Power-of-two memory with write and read pointers; read data is registered.
// ----------------------------------------------------------------------------
module urtx_ring #(
  parameter int RX_DEPTH = urtx_pkg::RX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  urtx_pkg::ring_cmd_t         cmd,
  input  logic [urtx_pkg::DATA_W-1:0] wr_data,
  output urtx_pkg::ring_stat_t        stat,
  output logic [urtx_pkg::DATA_W-1:0] rd_data
);

  localparam int PTR_W = $clog2(RX_DEPTH);

  logic [urtx_pkg::DATA_W-1:0] mem [RX_DEPTH];
  logic [PTR_W-1:0]            wr_ptr_r;
  logic [PTR_W-1:0]            rd_ptr_r;
  logic [urtx_pkg::DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]            wr_ptr_inc;
  logic [PTR_W-1:0]            fill;
  logic [31:0]                 fill_ext;

  // pointer arithmetic wraps naturally at the power-of-two depth
  assign wr_ptr_inc = wr_ptr_r + PTR_W'(1);
  assign fill       = wr_ptr_r - rd_ptr_r;
  assign fill_ext   = 32'(fill);

  // status
  assign stat.empty     = (wr_ptr_r == rd_ptr_r);
  assign stat.full      = (wr_ptr_inc == rd_ptr_r);
  assign stat.available = fill_ext[urtx_pkg::AVAIL_W-1:0];
  assign rd_data        = rd_data_r;

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr_r <= wr_ptr_inc;
      end
      if (cmd.pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // storage, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

### design/urtx_stats.sv
// ----------------------------------------------------------------------------
// urtx_stats: wrapping event counters
// Overflow, stored byte, error and completed frame counts.
// ----------------------------------------------------------------------------
module urtx_stats (
  input  logic                       clk,
  input  logic                       rst_n,
  input  urtx_pkg::stat_inc_t        inc,
  output logic [urtx_pkg::CNT_W-1:0] overflow_count,
  output logic [urtx_pkg::CNT_W-1:0] rx_count,
  output logic [urtx_pkg::CNT_W-1:0] error_count,
  output logic [urtx_pkg::CNT_W-1:0] frame_count
);

  logic [urtx_pkg::CNT_W-1:0] drop_r;
  logic [urtx_pkg::CNT_W-1:0] store_r;
  logic [urtx_pkg::CNT_W-1:0] fault_r;
  logic [urtx_pkg::CNT_W-1:0] sent_r;

  // counters, cleared by reset or reinitialize
  always_ff @(posedge clk) begin
    if (!rst_n || inc.clr) begin
      drop_r  <= '0;
      store_r <= '0;
      fault_r <= '0;
      sent_r  <= '0;
    end else begin
      if (inc.drop) begin
        drop_r <= drop_r + urtx_pkg::CNT_W'(1);
      end
      if (inc.store) begin
        store_r <= store_r + urtx_pkg::CNT_W'(1);
      end
      if (inc.fault) begin
        fault_r <= fault_r + urtx_pkg::CNT_W'(1);
      end
      if (inc.sent) begin
        sent_r <= sent_r + urtx_pkg::CNT_W'(1);
      end
    end
  end

  assign overflow_count = drop_r;
  assign rx_count       = store_r;
  assign error_count    = fault_r;
  assign frame_count    = sent_r;

endmodule

### design/uart_rx_ring_with_tx_busy.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_with_tx_busy: serial port receive ring and transmit tracker
// Handles one port event per transaction and reports status for each.
// ----------------------------------------------------------------------------
// An event is taken on any clock edge with start high; busy is always low, so
// one event per clock is sustained. Each event yields one result: the event is
// held in the input register, then passes through the decode logic into the
// ring pointers, counters, busy flag and result register, with the ring
// memory read port registered alongside. The result sits on the out_ ports
// for exactly one cycle marked by out_valid; the receiver cannot stall, so
// results must be captured when out_valid is high. Ring depth is RX_DEPTH
// (power of two) and holds at most RX_DEPTH-1 bytes.
module uart_rx_ring_with_tx_busy #(
  parameter int RX_DEPTH = urtx_pkg::RX_DEPTH_DEF,
  parameter int TX_MAX   = urtx_pkg::TX_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [urtx_pkg::KIND_W-1:0]  in_kind,
  input  logic                         in_own_port,
  input  logic [urtx_pkg::DATA_W-1:0]  in_rx_data,
  input  logic [urtx_pkg::LEN_W-1:0]   in_tx_length,
  input  logic                         in_start_ok,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [urtx_pkg::DATA_W-1:0]  out_read_data,
  output logic [urtx_pkg::AVAIL_W-1:0] out_available,
  output logic                         out_tx_busy,
  output logic [urtx_pkg::CNT_W-1:0]   out_overflow_count,
  output logic [urtx_pkg::CNT_W-1:0]   out_rx_count,
  output logic [urtx_pkg::CNT_W-1:0]   out_error_count,
  output logic [urtx_pkg::CNT_W-1:0]   out_frame_count
);

  localparam logic [urtx_pkg::LEN_W-1:0] TX_MAX_LEN = urtx_pkg::LEN_W'(TX_MAX);

  // input register
  logic                         in_valid_r;
  logic [urtx_pkg::KIND_W-1:0]  kind_r;
  logic                         own_r;
  logic [urtx_pkg::DATA_W-1:0]  rx_data_r;
  logic [urtx_pkg::LEN_W-1:0]   tx_len_r;
  logic                         start_ok_r;

  // event state and result register
  logic                         tx_busy_r;
  logic                         tx_busy_nxt;
  logic                         out_valid_r;
  logic                         out_ok_r;
  logic                         ok_nxt;
  logic                         rd_sel_r;

  urtx_pkg::ring_cmd_t          ring_cmd;
  urtx_pkg::ring_stat_t         ring_stat;
  urtx_pkg::stat_inc_t          stat_inc;
  logic [urtx_pkg::DATA_W-1:0]  ring_rd_data;
  logic                         len_ok;

  assign busy = 1'b0;

  // capture one transaction per clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind_r     <= in_kind;
      own_r      <= in_own_port;
      rx_data_r  <= in_rx_data;
      tx_len_r   <= in_tx_length;
      start_ok_r <= in_start_ok;
    end
  end

  assign len_ok = (tx_len_r != '0) && (tx_len_r <= TX_MAX_LEN);

  // event decode
  always_comb begin
    ring_cmd    = '0;
    stat_inc    = '0;
    tx_busy_nxt = tx_busy_r;
    ok_nxt      = 1'b0;
    if (in_valid_r) begin
      case (kind_r)
        urtx_pkg::KIND_RX_BYTE: begin
          if (own_r) begin
            if (ring_stat.full) begin
              stat_inc.drop = 1'b1;
            end else begin
              ring_cmd.push  = 1'b1;
              stat_inc.store = 1'b1;
            end
          end
        end
        urtx_pkg::KIND_READ: begin
          if (!ring_stat.empty) begin
            ring_cmd.pop = 1'b1;
            ok_nxt       = 1'b1;
          end
        end
        urtx_pkg::KIND_TX_REQ: begin
          if (len_ok && !tx_busy_r && start_ok_r) begin
            tx_busy_nxt = 1'b1;
            ok_nxt      = 1'b1;
          end
        end
        urtx_pkg::KIND_TX_DONE: begin
          if (own_r) begin
            tx_busy_nxt   = 1'b0;
            stat_inc.sent = 1'b1;
          end
        end
        urtx_pkg::KIND_ERROR: begin
          if (own_r) begin
            tx_busy_nxt    = 1'b0;
            stat_inc.fault = 1'b1;
          end
        end
        urtx_pkg::KIND_REINIT: begin
          ring_cmd.clr = 1'b1;
          stat_inc.clr = 1'b1;
          tx_busy_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // busy flag and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      rd_sel_r    <= 1'b0;
    end else begin
      tx_busy_r   <= tx_busy_nxt;
      out_valid_r <= in_valid_r;
      out_ok_r    <= ok_nxt;
      rd_sel_r    <= ring_cmd.pop;
    end
  end

  urtx_ring #(
    .RX_DEPTH (RX_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ring_cmd),
    .wr_data (rx_data_r),
    .stat    (ring_stat),
    .rd_data (ring_rd_data)
  );

  urtx_stats u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .inc            (stat_inc),
    .overflow_count (out_overflow_count),
    .rx_count       (out_rx_count),
    .error_count    (out_error_count),
    .frame_count    (out_frame_count)
  );

  // state registers already hold the post-event values during the strobe
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_read_data = rd_sel_r ? ring_rd_data : '0;
  assign out_available = ring_stat.available;
  assign out_tx_busy   = tx_busy_r;

endmodule
